>>> rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, item types and controller/datapath signal groups for the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned ArenaBytes   = 65536;
  localparam int unsigned GranuleBytes = 8;
  localparam int unsigned NumGranules  = ArenaBytes / GranuleBytes;
  localparam int unsigned SizeW        = $clog2(NumGranules);
  localparam int unsigned IdxW         = SizeW + 1;
  localparam int unsigned GranShift    = $clog2(GranuleBytes);

  localparam logic [1:0] ModeAlloc  = 2'd0;
  localparam logic [1:0] ModeFree   = 2'd1;
  localparam logic [1:0] ModeReinit = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] request_bytes;
    logic [15:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] payload_offset;
    logic [15:0] free_total;
    logic [15:0] largest_free;
  } out_item_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             free;
  } hdr_t;

  typedef struct packed {
    logic load;
    logic reinit;
    logic rd_g;
    logic rd_nxt;
    logic walk_start;
    logic hop;
    logic wr_split;
    logic wr_take;
    logic wr_mark;
    logic walk_cap;
    logic walk_merge;
    logic walk_step;
    logic walk_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       req_bad;
    logic       addr_null;
    logic       addr_odd;
    logic       g_end;
    logic       nxt_end;
    logic       fit;
    logic       split;
    logic       hit;
    logic       past;
    logic       merge;
    logic       can_out;
  } sts_t;

endpackage

>>> rtl/core/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over a 64 KiB arena kept as an implicit header list.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one operation per
// transfer: allocate, free or reinitialize. Output channel (out_valid_o /
// out_stall_i / out_data_o): one result per operation with status, payload
// offset, total free bytes and largest free block.
// One operation at a time. The search and the merge and statistics walk each
// read one block header per step through the registered header memory read
// port. Every block holds at least two granules, so there are at most 4096
// blocks.
// The next operation is taken as soon as the previous result sits in the
// output register; it holds there while out_stall_i is high, and a later
// finished result waits until it has gone.
// Reset leaves the arena as one free block of 8191 granules; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ffha_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ffha_pkg::out_item_t  out_data_o
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: input transfer, block search, split/mark writes, merge and
// statistics walk, result hand-off.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffha_pkg::sts_t  sts_i,
  output ffha_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StDispatch = 4'd1;
  localparam logic [3:0] StSrchRd   = 4'd2;
  localparam logic [3:0] StSrchEv   = 4'd3;
  localparam logic [3:0] StTake     = 4'd4;
  localparam logic [3:0] StWalk0    = 4'd5;
  localparam logic [3:0] StWalkCap  = 4'd6;
  localparam logic [3:0] StWalkRd   = 4'd7;
  localparam logic [3:0] StWalkEv   = 4'd8;
  localparam logic [3:0] StDone     = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDispatch;
        end
      end
      StDispatch: begin
        state_d = StWalk0;
        if (sts_i.mode == ffha_pkg::ModeAlloc && !sts_i.req_bad) begin
          state_d = StSrchRd;
        end else if (sts_i.mode == ffha_pkg::ModeFree && !sts_i.addr_null
                     && !sts_i.addr_odd) begin
          state_d = StSrchRd;
        end else if (sts_i.mode == ffha_pkg::ModeReinit) begin
          cmd_o.reinit = 1'b1;
        end
      end
      StSrchRd: begin
        if (sts_i.g_end) begin
          state_d = StWalk0;
        end else begin
          cmd_o.rd_g = 1'b1;
          state_d    = StSrchEv;
        end
      end
      StSrchEv: begin
        if (sts_i.mode == ffha_pkg::ModeAlloc) begin
          if (sts_i.fit && sts_i.split) begin
            cmd_o.wr_split = 1'b1;
            state_d        = StTake;
          end else if (sts_i.fit) begin
            cmd_o.wr_take = 1'b1;
            state_d       = StWalk0;
          end else begin
            cmd_o.hop = 1'b1;
            state_d   = StSrchRd;
          end
        end else begin
          if (sts_i.hit) begin
            cmd_o.wr_mark = 1'b1;
            state_d       = StWalk0;
          end else if (sts_i.past) begin
            state_d = StWalk0;
          end else begin
            cmd_o.hop = 1'b1;
            state_d   = StSrchRd;
          end
        end
      end
      StTake: begin
        cmd_o.wr_take = 1'b1;
        state_d       = StWalk0;
      end
      StWalk0: begin
        cmd_o.walk_start = 1'b1;
        state_d          = StWalkCap;
      end
      StWalkCap: begin
        cmd_o.walk_cap = 1'b1;
        state_d        = StWalkRd;
      end
      StWalkRd: begin
        if (sts_i.nxt_end) begin
          cmd_o.walk_fin = 1'b1;
          state_d        = StDone;
        end else begin
          cmd_o.rd_nxt = 1'b1;
          state_d      = StWalkEv;
        end
      end
      StWalkEv: begin
        if (sts_i.merge) begin
          cmd_o.walk_merge = 1'b1;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
        state_d = StWalkRd;
      end
      StDone: begin
        if (sts_i.can_out) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory, block cursor, split/mark/merge arithmetic, free
// statistics and the result register.
// ----------------------------------------------------------------------------
module ffha_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffha_pkg::in_item_t   in_data_i,
  input  ffha_pkg::cmd_t       cmd_i,
  output ffha_pkg::sts_t       sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output ffha_pkg::out_item_t  out_data_o
);

  localparam int unsigned SizeW = ffha_pkg::SizeW;
  localparam int unsigned IdxW  = ffha_pkg::IdxW;
  localparam int unsigned GrSh  = ffha_pkg::GranShift;

  ffha_pkg::hdr_t      mem [ffha_pkg::NumGranules];
  ffha_pkg::hdr_t      mem_rd_q;
  logic                rd_zero_q;
  ffha_pkg::hdr_t      hdr0_q;
  ffha_pkg::hdr_t      cur_q;
  ffha_pkg::hdr_t      rdata;
  logic [1:0]          mode_q;
  logic [16:0]         req_q;
  logic [15:0]         addr_q;
  logic [IdxW-1:0]     g_q;
  logic [SizeW-1:0]    tot_q;
  logic [SizeW-1:0]    best_q;
  logic                ok_q;
  logic [15:0]         off_q;
  logic                out_valid_q;
  ffha_pkg::out_item_t out_q;

  logic [17:0]         req_up;
  logic [IdxW-1:0]     need;
  logic [IdxW-1:0]     have_x;
  logic [IdxW-1:0]     nxt;
  logic [IdxW-1:0]     hop_g;
  logic [IdxW-1:0]     split_at;
  logic [IdxW-1:0]     target;
  logic [SizeW-1:0]    merged;
  logic [IdxW+GrSh-1:0] off_full;
  logic [SizeW+GrSh-1:0] tot_bytes;
  logic [SizeW+GrSh-1:0] best_bytes;
  logic                acc;

  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  ffha_pkg::hdr_t      wr_data;

  assign rdata    = rd_zero_q ? hdr0_q : mem_rd_q;
  assign req_up   = {1'b0, req_q} + 18'(ffha_pkg::GranuleBytes - 1);
  assign need     = req_up[IdxW+GrSh-1:GrSh];
  assign have_x   = IdxW'(rdata.size);
  assign nxt      = g_q + IdxW'(cur_q.size) + IdxW'(1);
  assign hop_g    = g_q + have_x + IdxW'(1);
  assign split_at = g_q + need + IdxW'(1);
  assign target   = IdxW'(addr_q[15:GrSh]) - IdxW'(1);
  assign merged   = cur_q.size + rdata.size + SizeW'(1);
  assign off_full = (IdxW+GrSh)'(g_q + IdxW'(1)) << GrSh;
  assign tot_bytes  = {tot_q, {GrSh{1'b0}}};
  assign best_bytes = {best_q, {GrSh{1'b0}}};
  assign acc      = (cmd_i.walk_step || cmd_i.walk_fin) && cur_q.free;

  always_comb begin
    sts_o           = '0;
    sts_o.mode      = mode_q;
    sts_o.req_bad   = (req_q == 17'd0) || (req_q > 17'(ffha_pkg::ArenaBytes));
    sts_o.addr_null = (addr_q == 16'd0);
    sts_o.addr_odd  = (addr_q[GrSh-1:0] != '0);
    sts_o.g_end     = g_q[IdxW-1];
    sts_o.nxt_end   = nxt[IdxW-1];
    sts_o.fit       = rdata.free && (have_x >= need);
    sts_o.split     = (have_x >= need + IdxW'(2));
    sts_o.hit       = (g_q == target);
    sts_o.past      = (g_q > target);
    sts_o.merge     = cur_q.free && rdata.free;
    sts_o.can_out   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    rd_en   = cmd_i.rd_g || cmd_i.rd_nxt || cmd_i.walk_start;
    rd_addr = '0;
    if (cmd_i.rd_g) begin
      rd_addr = g_q;
    end else if (cmd_i.rd_nxt) begin
      rd_addr = nxt;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = g_q;
    wr_data = '0;
    if (cmd_i.wr_split) begin
      wr_addr      = split_at;
      wr_data.size = rdata.size - need[SizeW-1:0] - SizeW'(1);
      wr_data.free = 1'b1;
    end else if (cmd_i.wr_take) begin
      wr_data.size = sts_o.split ? need[SizeW-1:0] : rdata.size;
      wr_data.free = 1'b0;
    end else if (cmd_i.wr_mark) begin
      wr_data.size = rdata.size;
      wr_data.free = 1'b1;
    end else if (cmd_i.walk_merge) begin
      wr_data.size = merged;
      wr_data.free = 1'b1;
    end else if (cmd_i.reinit) begin
      wr_addr      = '0;
      wr_data.size = SizeW'(ffha_pkg::NumGranules - 1);
      wr_data.free = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr[SizeW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q  <= mem[rd_addr[SizeW-1:0]];
      rd_zero_q <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q.size <= SizeW'(ffha_pkg::NumGranules - 1);
      hdr0_q.free <= 1'b1;
    end else if (wr_en && (wr_addr == '0)) begin
      hdr0_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else if (cmd_i.load || cmd_i.walk_start) begin
      g_q <= '0;
    end else if (cmd_i.hop) begin
      g_q <= hop_g;
    end else if (cmd_i.walk_step) begin
      g_q <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      req_q  <= in_data_i.request_bytes;
      addr_q <= in_data_i.free_address;
      ok_q   <= (in_data_i.mode == ffha_pkg::ModeFree)
                || (in_data_i.mode == ffha_pkg::ModeReinit);
      off_q  <= '0;
    end else if (cmd_i.wr_take) begin
      ok_q  <= 1'b1;
      off_q <= off_full[15:0];
    end

    if (cmd_i.walk_cap || cmd_i.walk_step) begin
      cur_q <= rdata;
    end else if (cmd_i.walk_merge) begin
      cur_q.size <= merged;
    end

    if (cmd_i.load) begin
      tot_q  <= '0;
      best_q <= '0;
    end else if (acc) begin
      tot_q <= tot_q + cur_q.size;
      if (cur_q.size > best_q) begin
        best_q <= cur_q.size;
      end
    end

    if (cmd_i.out_load) begin
      out_q.ok             <= ok_q;
      out_q.payload_offset <= off_q;
      out_q.free_total     <= 16'(tot_bytes);
      out_q.largest_free   <= 16'(best_bytes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(g_q[IdxW-1] && (g_q[IdxW-2:0] != '0)))
    else $error("block cursor beyond arena end");

  a_split_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_split |-> (sts_o.fit && sts_o.split))
    else $error("split written without a fitting block");

  a_total_ge_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_total >= out_data_o.largest_free))
    else $error("largest free block exceeds free total");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.payload_offset != 16'd0)) |-> out_data_o.ok)
    else $error("nonzero offset on a failed operation");
`endif

endmodule

>>> verif/first_fit_heap_allocator_core_chk.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_chk
// Watches both channels of the first-fit allocator, keeps its own copy of the
// header list and checks every result against the predicted one, in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  ffha_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  ffha_pkg::out_item_t           out_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumGranules  = ffha_pkg::NumGranules;
  localparam int unsigned SizeW        = ffha_pkg::SizeW;
  localparam int unsigned GranuleBytes = ffha_pkg::GranuleBytes;
  localparam int unsigned LastSize     = NumGranules - 1;

  logic [SizeW-1:0]    blk_size [NumGranules];
  logic                blk_free [NumGranules];
  ffha_pkg::out_item_t result_q [$];

  function automatic int unsigned next_blk(int unsigned g);
    return g + 1 + blk_size[g];
  endfunction

  function automatic void arena_clear();
    for (int i = 0; i < NumGranules; i++) begin
      blk_size[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = LastSize[SizeW-1:0];
    blk_free[0] = 1'b1;
  endfunction

  function automatic ffha_pkg::out_item_t predict_op(ffha_pkg::in_item_t op);
    ffha_pkg::out_item_t r;
    int unsigned need, have, t, tgt, n, bytes;
    r = '0;
    if (op.mode == ffha_pkg::ModeAlloc) begin
      if (op.request_bytes != 0 && op.request_bytes <= ffha_pkg::ArenaBytes) begin
        need = (int'(op.request_bytes) + GranuleBytes - 1) / GranuleBytes;
        for (int unsigned g = 0; g < NumGranules; g = next_blk(g)) begin
          have = blk_size[g];
          if (!blk_free[g] || have < need) continue;
          if (have - need >= 2) begin
            t = g + 1 + need;
            if (t < NumGranules) begin
              blk_size[t] = SizeW'(have - need - 1);
              blk_free[t] = 1'b1;
              blk_size[g] = SizeW'(need);
            end
          end
          blk_free[g] = 1'b0;
          r.ok = 1'b1;
          r.payload_offset = 16'((g + 1) * GranuleBytes);
          break;
        end
      end
    end else if (op.mode == ffha_pkg::ModeFree) begin
      r.ok = 1'b1;
      if (op.free_address != 0) begin
        if (op.free_address % GranuleBytes == 0) begin
          tgt = op.free_address / GranuleBytes - 1;
          for (int unsigned g = 0; g < NumGranules; g = next_blk(g)) begin
            if (g == tgt) begin
              blk_free[g] = 1'b1;
              break;
            end
            if (g > tgt) break;
          end
        end
        for (int unsigned g = 0; g < NumGranules; g = next_blk(g)) begin
          if (!blk_free[g]) continue;
          for (n = next_blk(g); n < NumGranules && blk_free[n]; n = next_blk(g))
            blk_size[g] = SizeW'(blk_size[g] + 1 + blk_size[n]);
        end
      end
    end else if (op.mode == ffha_pkg::ModeReinit) begin
      arena_clear();
      r.ok = 1'b1;
    end
    for (int unsigned g = 0; g < NumGranules; g = next_blk(g)) begin
      if (blk_free[g]) begin
        bytes = blk_size[g] * GranuleBytes;
        r.free_total = r.free_total + 16'(bytes);
        if (bytes > r.largest_free) r.largest_free = 16'(bytes);
      end
    end
    return r;
  endfunction

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ffha_pkg::out_item_t want;
    int                  bad;
    bad = 0;
    if (!rst_ni) begin
      arena_clear();
      result_q.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) result_q.push_back(predict_op(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_data_i);
          bad++;
        end else begin
          want = result_q.pop_front();
          if (want.ok !== out_data_i.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data_i.ok);
            bad++;
          end
          if (want.payload_offset !== out_data_i.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, out_data_i.payload_offset);
            bad++;
          end
          if (want.free_total !== out_data_i.free_total) begin
            $error("free_total: expected %0d, got %0d",
                   want.free_total, out_data_i.free_total);
            bad++;
          end
          if (want.largest_free !== out_data_i.largest_free) begin
            $error("largest_free: expected %0d, got %0d",
                   want.largest_free, out_data_i.largest_free);
            bad++;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

endmodule

>>> verif/first_fit_heap_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_tb
// Drives allocate, free, reinitialize and spare-mode operations into the allocator under
// random idling on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeAlloc  = ffha_pkg::ModeAlloc;
  localparam logic [1:0] ModeFree   = ffha_pkg::ModeFree;
  localparam logic [1:0] ModeReinit = ffha_pkg::ModeReinit;
  localparam logic [1:0] ModeSpare  = 2'd3;

  logic                clk, rst_n;
  logic                in_valid, in_stall, out_valid, out_stall;
  ffha_pkg::in_item_t  in_data;
  ffha_pkg::out_item_t out_data;
  int                  errors, pending;
  int                  tx_idle_pct, rx_idle_pct;
  bit                  rx_hold;
  int                  live_q [$];

  first_fit_heap_allocator_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  first_fit_heap_allocator_core_chk i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
    if (out_valid && !out_stall && out_data.payload_offset != 0)
      live_q.push_back(out_data.payload_offset);
  end

  task automatic send_op(logic [1:0] mode, logic [16:0] req, logic [15:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, request_bytes: req, free_address: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int pick, idx;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      if ($urandom_range(0, 9) == 0) send_op(ModeAlloc, 17'($urandom()), 16'($urandom()));
      else send_op(ModeAlloc, 17'($urandom_range(1, 3000)), 16'($urandom()));
    end else if (pick < 88) begin
      if (live_q.size() != 0 && $urandom_range(0, 9) != 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        send_op(ModeFree, 17'($urandom()), 16'(live_q[idx]));
        live_q.delete(idx);
      end else begin
        send_op(ModeFree, 17'($urandom()), 16'($urandom()));
      end
    end else if (pick < 94) begin
      send_op(ModeReinit, 17'($urandom()), 16'($urandom()));
      live_q.delete();
    end else begin
      send_op(ModeSpare, 17'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rx_hold = 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(ModeAlloc, 17'd0, 16'hffff);
    send_op(ModeAlloc, 17'h1ffff, 16'd0);
    send_op(ModeAlloc, 17'd65536, 16'd0);
    send_op(ModeAlloc, 17'd65528, 16'd0);
    send_op(ModeAlloc, 17'd1, 16'd0);
    send_op(ModeFree, 17'd0, 16'd8);
    send_op(ModeFree, 17'd0, 16'd8);
    send_op(ModeAlloc, 17'd1, 16'd0);
    send_op(ModeAlloc, 17'd8, 16'd0);
    send_op(ModeAlloc, 17'd9, 16'd0);
    send_op(ModeAlloc, 17'd24, 16'd0);
    send_op(ModeFree, 17'h1ffff, 16'd0);
    send_op(ModeFree, 17'd0, 16'd13);
    send_op(ModeFree, 17'd0, 16'hffff);
    send_op(ModeFree, 17'd0, 16'hfff8);
    send_op(ModeFree, 17'd0, 16'd24);
    send_op(ModeFree, 17'd0, 16'd16);
    send_op(ModeFree, 17'd0, 16'd48);
    send_op(ModeSpare, 17'h1ffff, 16'hffff);
    send_op(ModeAlloc, 17'd65512, 16'd0);
    send_op(ModeReinit, 17'd0, 16'd0);
    drain();
    live_q.delete();

    repeat (35) random_op();
    drain();

    tx_idle_pct = 64;
    rx_idle_pct = 35;
    repeat (35) random_op();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      repeat (35) random_op();
    join

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
